// ===== src/ffr_pkg.sv =====
// ----------------------------------------------------------------------------
// ffr_pkg: shared types and constants of the FIFO frame replacement block
// Frame count, field widths, opcodes and the payload structs of both sides.
// ----------------------------------------------------------------------------
package ffr_pkg;

	// Number of cells in the order chain and the widths derived from it.
	localparam int FRAMES = 64;
	localparam int POS_W  = $clog2(FRAMES);
	localparam int CNT_W  = $clog2(FRAMES + 1);

	// Fixed field widths.
	localparam int FRAME_W = 6;
	localparam int OP_W    = 2;
	localparam int CFG_W   = 7;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
	localparam logic [OP_W-1:0] OP_EVICT  = 2'd2;

	// Status codes.
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	// Reset value of the frames-in-use register.
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [FRAME_W-1:0] frame;
	} ffr_cmd_t;

	typedef struct packed {
		logic               status;
		logic               victim_valid;
		logic [FRAME_W-1:0] victim_frame;
		logic [CNT_W-1:0]   occupancy;
	} ffr_result_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic               sample;
		logic               load;
		logic               evict;
		logic [FRAME_W-1:0] frame;
		logic [POS_W-1:0]   pos;
		logic [CNT_W-1:0]   count;
	} ffr_cell_ctrl_t;

endpackage

// ===== src/ffr_cell.sv =====
// ----------------------------------------------------------------------------
// ffr_cell: one position of the replacement order
// Holds one queued frame, flags a match against the command frame, takes a
// newly loaded frame at the tail and shifts toward the head on eviction.
// ----------------------------------------------------------------------------
module ffr_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffr_pkg::ffr_cell_ctrl_t        ctrl,
	input  logic [ffr_pkg::POS_W-1:0]      idx,
	input  logic [ffr_pkg::FRAME_W-1:0]    next_entry,
	output logic [ffr_pkg::FRAME_W-1:0]    entry,
	output logic                           match
);
	import ffr_pkg::*;

	logic [FRAME_W-1:0] entry_q;
	logic               match_q;
	logic               occupied;
	logic               is_tail;
	logic               shift;

	// Position decode against the current fill level and evicted position.
	assign occupied = {1'b0, idx} < ctrl.count;
	assign is_tail  = {1'b0, idx} == ctrl.count;
	assign shift    = ctrl.evict && (idx >= ctrl.pos);

	// Match flag, registered in the match phase, the cycle before the commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.sample) begin
			match_q <= occupied && (entry_q == ctrl.frame);
		end
	end

	// Entry storage: close the gap on eviction, take the frame on a tail load.
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= next_entry;
		end else if (ctrl.load && is_tail) begin
			entry_q <= ctrl.frame;
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ===== src/ffr_enc.sv =====
// ----------------------------------------------------------------------------
// ffr_enc: match position encoder
// Turns the one-hot match flags of the cells into a position and a hit flag.
// ----------------------------------------------------------------------------
module ffr_enc (
	input  logic [ffr_pkg::FRAMES-1:0]  match_vec,
	output logic [ffr_pkg::POS_W-1:0]   pos,
	output logic                        hit
);
	import ffr_pkg::*;

	// Each position bit is the OR of the flags whose index has that bit set.
	always_comb begin
		pos = '0;
		for (int i = 0; i < FRAMES; i++) begin
			pos = pos | (match_vec[i] ? POS_W'(i) : '0);
		end
	end

	assign hit = |match_vec;

endmodule

// ===== src/fifo_frame_replacement.sv =====
// ----------------------------------------------------------------------------
// fifo_frame_replacement: FIFO order of loaded memory frames
// The result strobe follows the match phase and the commit phase, and is registered.
// One command is in flight at a time; busy covers the match cycle (cells
// compare their entries) and the commit cycle (encode, shift or append).
// A new command may be accepted in the cycle the result is shown.
// Reset clears the fill count and all loaded marks; frames-in-use returns to 64.
// ----------------------------------------------------------------------------
module fifo_frame_replacement (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ffr_pkg::ffr_cmd_t             cmd,
	output logic                          done,
	output ffr_pkg::ffr_result_t          result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ffr_pkg::CFG_W-1:0]     cfg_data
);
	import ffr_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_MATCH  = 2'd1;
	localparam logic [1:0] PH_COMMIT = 2'd2;

	logic [1:0]          phase_q;
	logic                done_q;
	logic                status_q;
	logic [CFG_W-1:0]    frames_in_use_q;
	logic [CNT_W-1:0]    count_q;
	logic [FRAMES-1:0]   marks_q;
	logic [OP_W-1:0]     opcode_q;
	logic [FRAME_W-1:0]  frame_q;

	logic [CNT_W-1:0]    limit;
	logic                in_range;
	logic                mark;
	logic                full;
	logic                do_load;
	logic                do_evict;
	logic                status_d;
	logic                accept;
	logic                commit;
	logic [POS_W-1:0]    pos;
	logic                hit;

	ffr_cell_ctrl_t      ctrl;
	logic [FRAME_W-1:0]  entries [FRAMES];
	logic [FRAMES-1:0]   match_vec;

	assign accept    = start && !busy;
	assign busy      = (phase_q == PH_MATCH) || (phase_q == PH_COMMIT);
	assign commit    = (phase_q == PH_COMMIT);
	// The register only changes while no item is in flight.
	assign cfg_ready = !busy;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_in_use_q <= cfg_data;
		end
	end

	// Command capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= cmd.opcode;
			frame_q  <= cmd.frame;
		end
	end

	// Sequencer: match, then commit, then show the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= commit;
			case (phase_q)
				PH_IDLE:   phase_q <= accept ? PH_MATCH : PH_IDLE;
				PH_MATCH:  phase_q <= PH_COMMIT;
				PH_COMMIT: phase_q <= PH_IDLE;
				default:   phase_q <= PH_IDLE;
			endcase
		end
	end

	// Operation decode; the limit saturates at the cell count.
	assign limit    = (frames_in_use_q > CFG_W'(FRAMES)) ? CNT_W'(FRAMES)
	                                                     : CNT_W'(frames_in_use_q);
	assign in_range = CNT_W'(frame_q) < limit;
	assign mark     = marks_q[frame_q[POS_W-1:0]];
	assign full     = count_q >= limit;

	always_comb begin
		do_load  = 1'b0;
		do_evict = 1'b0;
		status_d = ST_FAIL;
		case (opcode_q)
			OP_LOAD: begin
				if (in_range && mark) begin
					status_d = ST_OK;
				end else if (in_range && !full) begin
					status_d = ST_OK;
					do_load  = 1'b1;
				end
			end
			OP_ACCESS: begin
				status_d = (in_range && mark) ? ST_OK : ST_FAIL;
			end
			OP_EVICT: begin
				if (in_range && mark && hit) begin
					status_d = ST_OK;
					do_evict = 1'b1;
				end
			end
			default: status_d = ST_FAIL;
		endcase
	end

	// Fill count, loaded marks and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			marks_q  <= '0;
			status_q <= ST_OK;
		end else if (commit) begin
			status_q <= status_d;
			if (do_load) begin
				count_q                        <= count_q + CNT_W'(1);
				marks_q[frame_q[POS_W-1:0]]    <= 1'b1;
			end else if (do_evict) begin
				count_q                        <= count_q - CNT_W'(1);
				marks_q[frame_q[POS_W-1:0]]    <= 1'b0;
			end
		end
	end

	// Broadcast control to the chain.
	always_comb begin
		ctrl.sample = (phase_q == PH_MATCH);
		ctrl.load   = commit && do_load;
		ctrl.evict  = commit && do_evict;
		ctrl.frame  = frame_q;
		ctrl.pos    = pos;
		ctrl.count  = count_q;
	end

	// Chain of cells; each but the last takes its younger neighbor's entry on a shift, the last keeps its own.
	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		logic [FRAME_W-1:0] next_entry;
		if (i == FRAMES - 1) begin : g_last
			assign next_entry = entries[i];
		end else begin : g_mid
			assign next_entry = entries[i+1];
		end
		ffr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.idx        (POS_W'(i)),
			.next_entry (next_entry),
			.entry      (entries[i]),
			.match      (match_vec[i])
		);
	end

	ffr_enc u_enc (
		.match_vec (match_vec),
		.pos       (pos),
		.hit       (hit)
	);

	// Result from the committed state.
	assign done                = done_q;
	assign result.status       = status_q;
	assign result.victim_valid = count_q != '0;
	assign result.victim_frame = (count_q != '0) ? entries[0] : '0;
	assign result.occupancy    = count_q;

	// The fill count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FRAMES))
		else $error("fill count above cell count");

	// The number of loaded marks equals the fill count.
	a_marks_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(marks_q) == 32'(count_q))
		else $error("loaded marks disagree with fill count");

	// At commit, the command frame matches at most one cell.
	a_match_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> $onehot0(match_vec))
		else $error("frame matched in more than one cell");

	// Every commit is followed by exactly one result strobe.
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> done)
		else $error("commit without result");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the FIFO frame replacement block
// Drives load, access, evict and unused-opcode commands through the start/busy port while
// the frames-in-use register is moved between settings, including zero and
// values above the frame count. A scoreboard tracks its own copy of the
// frame order and loaded marks and checks every strobed result against it.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffr_pkg::*;

	localparam int LATENCY     = 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Scoreboard: shadow copy of the frame order and the expected results.
	class frame_order_board;
		logic [CFG_W-1:0]   frames_in_use;
		logic [FRAME_W-1:0] fifo_order[$];
		bit                 loaded[FRAMES];
		ffr_result_t        awaited[$];
		int                 errors;

		function new();
			frames_in_use = CFG_RESET;
			errors = 0;
		endfunction

		function void set_frames(logic [CFG_W-1:0] value);
			frames_in_use = value;
		endfunction

		// Frames in use saturate at the number of cells.
		function int capacity();
			return (frames_in_use > FRAMES) ? FRAMES : int'(frames_in_use);
		endfunction

		function logic [FRAME_W-1:0] pick_queued();
			return fifo_order[$urandom_range(0, fifo_order.size() - 1)];
		endfunction

		// Apply one accepted item to the shadow state and queue its result.
		function void note_command(ffr_cmd_t c);
			int          lim;
			ffr_result_t e;
			lim = capacity();
			e.status = ST_FAIL;
			if (int'(c.frame) < lim) begin
				case (c.opcode)
					OP_LOAD: begin
						if (loaded[c.frame]) begin
							e.status = ST_OK;
						end else if (fifo_order.size() < lim) begin
							fifo_order.push_back(c.frame);
							loaded[c.frame] = 1'b1;
							e.status = ST_OK;
						end
					end
					OP_ACCESS: begin
						e.status = loaded[c.frame] ? ST_OK : ST_FAIL;
					end
					OP_EVICT: begin
						if (loaded[c.frame]) begin
							foreach (fifo_order[i]) begin
								if (fifo_order[i] == c.frame) begin
									fifo_order.delete(i);
									break;
								end
							end
							loaded[c.frame] = 1'b0;
							e.status = ST_OK;
						end
					end
					default: e.status = ST_FAIL;
				endcase
			end
			e.victim_valid = fifo_order.size() > 0;
			e.victim_frame = (fifo_order.size() > 0) ? fifo_order[0] : '0;
			e.occupancy    = CNT_W'(fifo_order.size());
			awaited.push_back(e);
		endfunction

		// Compare one strobed result with the oldest expectation.
		function void check_result(ffr_result_t r);
			ffr_result_t e;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result: status=%0d victim=%0d/%0d occ=%0d",
						r.status, r.victim_valid, r.victim_frame, r.occupancy);
				return;
			end
			e = awaited.pop_front();
			if (r.status !== e.status || r.victim_valid !== e.victim_valid ||
				r.victim_frame !== e.victim_frame || r.occupancy !== e.occupancy) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch at %0t: exp status=%0d victim=%0d/%0d occ=%0d, %s%0d %0d/%0d %0d",
						$realtime, e.status, e.victim_valid, e.victim_frame, e.occupancy,
						"got status=", r.status, r.victim_valid, r.victim_frame,
						r.occupancy);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	ffr_cmd_t             cmd = '0;
	logic                 done;
	ffr_result_t          result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   cycles = 0;
	frame_order_board     board = new();

	fifo_frame_replacement dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Results are valid for one cycle only, so check every strobe.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	// Hold one item on the port until the block takes it.
	task automatic issue(input logic [OP_W-1:0] opc, input logic [FRAME_W-1:0] frm);
		ffr_cmd_t c;
		c.opcode = opc;
		c.frame  = frm;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		board.note_command(c);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Wait until every expected result is in and the block has settled.
	task automatic drain();
		start <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_frames(value);
	endtask

	// Random items, biased toward loads and toward evicts of queued frames.
	task automatic random_phase(input int count, input int idle_pct);
		int                 r;
		int                 lim;
		logic [OP_W-1:0]    opc;
		logic [FRAME_W-1:0] frm;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			lim = board.capacity();
			if (r < 3)
				opc = OP_UNUSED;
			else if (r < 50)
				opc = OP_LOAD;
			else if (r < 65)
				opc = OP_ACCESS;
			else
				opc = OP_EVICT;
			if (opc == OP_EVICT && board.fifo_order.size() > 0 && $urandom_range(0, 3) != 0)
				frm = board.pick_queued();
			else if (lim > 0 && $urandom_range(0, 9) != 0)
				frm = FRAME_W'($urandom_range(0, lim - 1));
			else
				frm = FRAME_W'($urandom_range(0, FRAMES - 1));
			issue(opc, frm);
			if ($urandom_range(0, 99) < idle_pct)
				pause($urandom_range(1, 5));
		end
	endtask

	initial begin
		int phase_frames[9];
		int phase_idle[4];
		phase_frames = '{64, 4, 127, 1, 33, 0, 2, 64, 65};
		phase_idle   = '{0, 66, 0, 36};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset setting: basic operations and edge frames.
		issue(OP_LOAD, 6'd0);
		issue(OP_LOAD, 6'd63);
		issue(OP_LOAD, 6'd0);
		issue(OP_ACCESS, 6'd0);
		issue(OP_ACCESS, 6'd5);
		issue(OP_EVICT, 6'd5);
		issue(OP_UNUSED, 6'd63);
		issue(OP_EVICT, 6'd0);
		issue(OP_EVICT, 6'd63);

		// A zero setting rejects every frame.
		write_frames(7'd0);
		issue(OP_LOAD, 6'd0);
		issue(OP_ACCESS, 6'd0);

		// Two frames: fill, then lower the setting below the occupancy.
		write_frames(7'd2);
		issue(OP_LOAD, 6'd1);
		issue(OP_LOAD, 6'd0);
		issue(OP_LOAD, 6'd2);
		write_frames(7'd1);
		issue(OP_ACCESS, 6'd1);
		issue(OP_EVICT, 6'd1);
		issue(OP_LOAD, 6'd0);
		issue(OP_EVICT, 6'd0);
		issue(OP_LOAD, 6'd0);

		// All ones saturates at the cell count.
		write_frames(7'd127);
		issue(OP_LOAD, 6'd42);
		issue(OP_ACCESS, 6'd1);
		issue(OP_EVICT, 6'd1);

		// Random phases across settings and idling patterns.
		for (int p = 0; p < 9; p++) begin
			write_frames(CFG_W'(phase_frames[p]));
			random_phase(50, phase_idle[p % 4]);
		end

		drain();
		if (board.errors == 0 && board.awaited.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
